[rtl/mrac_pkg.sv]
`default_nettype none

package mrac_pkg;

    localparam int POLY_DEGREE_DEF = 24;
    localparam int KEPT_TERMS_DEF  = 19;

    localparam int IN_W      = 48;
    localparam int OUT_TERMS = 19;
    localparam int OUT_W     = 2 * OUT_TERMS;
    localparam int CNT_W     = 8;
    localparam int ST_W      = 2;

    localparam logic [8:0] FIELD_POLY = 9'h14d;
    localparam int         MONO_EXP   = 146;
    localparam int         STEP_W     = $clog2(MONO_EXP);
    localparam int         EXP_W      = 8;

    localparam logic [CNT_W-1:0] RANGE_LOW  = CNT_W'(24);
    localparam logic [CNT_W-1:0] RANGE_HIGH = CNT_W'(37);

    localparam int LANES      = 16;
    localparam int LANE_BITS  = $clog2(LANES);
    localparam int GROUP_BITS = 8 - LANE_BITS;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_CONST = 2'd1;
    localparam logic [ST_W-1:0] ST_HIGH  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef logic [255:0][7:0] byte_table_t;

    typedef struct packed {
        logic                  load;
        logic                  reduce;
        logic                  prep;
        logic                  step;
        logic                  first;
        logic                  compare;
        logic                  finish;
        logic [GROUP_BITS-1:0] group;
    } dp_cmd_t;

    function automatic logic [1:0] gf4_mul(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] r;
        if (a == 2'd0 || b == 2'd0)
            r = 2'd0;
        else if (a == 2'd1)
            r = b;
        else if (b == 2'd1)
            r = a;
        else if (a == b)
            r = (a == 2'd2) ? 2'd3 : 2'd2;
        else
            r = 2'd1;
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = 8'd0;
        aa  = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ aa;
            aa = {aa[6:0], 1'b0} ^ (aa[7] ? FIELD_POLY[7:0] : 8'd0);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_pow(input logic [7:0] base);
        logic [7:0]       r;
        logic [7:0]       b;
        logic [EXP_W-1:0] e;
        r = 8'd1;
        b = base;
        e = EXP_W'(MONO_EXP);
        for (int i = 0; i < EXP_W; i++)
        begin
            if (e[i])
                r = gf_mul(r, b);
            b = gf_mul(b, b);
        end
        return r;
    endfunction

    function automatic logic [7:0] find_lift();
        logic [7:0] res;
        logic [7:0] sq;
        logic       found;
        res   = 8'd0;
        found = 1'b0;
        for (int v = 2; v < 256; v++)
        begin
            sq = gf_mul(8'(v), 8'(v));
            if (!found && gf_mul(sq, sq) == 8'(v))
            begin
                res   = 8'(v);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic byte_table_t build_pow_table();
        byte_table_t t;
        for (int p = 0; p < 256; p++)
            t[p] = gf_pow(8'(p));
        return t;
    endfunction

    localparam logic [7:0]  LIFT_TWO = find_lift();
    localparam byte_table_t POW_TAB  = build_pow_table();

    function automatic logic [7:0] lift(input logic [1:0] code);
        logic [7:0] r;
        case (code)
            2'd0:    r = 8'd0;
            2'd1:    r = 8'd1;
            2'd2:    r = LIFT_TWO;
            default: r = LIFT_TWO ^ 8'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/monomial_residue_agreement_count.sv]
// Monomial residue agreement counter.
// Input channel (in_valid/in_ready) carries one item: the 24 GF(4) codes
// of a monic polynomial P. Output channel (out_valid/out_ready) returns one
// item per input: the low remainder codes of x^146 mod P, the number of
// nonzero GF(256) points where the lifted remainder equals point^146, and
// a status code.
// From acceptance to out_valid: shift-and-reduce up to x^146 (one step a
// cycle), a step to load the Horner taps, then 16 groups of 16 points,
// each group taking one Horner step per kept term in the shared lane
// multipliers plus a compare step, then a step to register the result.
// One item is in work at a time; in_ready is high only while the
// sequencer is idle, so a new item is not accepted until the last one
// has left the sequencer.
// The result sits in an output register: the next item is accepted while
// it waits. If a finished item meets a stalled receiver, the sequencer
// holds in its final state until the output register frees.
// Reset clears the sequencer and out_valid; no item is in work after it.
`default_nettype none

module monomial_residue_agreement_count
    import mrac_pkg::*;
#(
    parameter int POLY_DEGREE = POLY_DEGREE_DEF,
    parameter int KEPT_TERMS  = KEPT_TERMS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [IN_W-1:0]   elementary_coeffs,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       remainder_coeffs,
    output logic [CNT_W-1:0]       agreement_total,
    output logic [ST_W-1:0]        status
);

    dp_cmd_t cmd;

    mrac_controller #(
        .KEPT_TERMS (KEPT_TERMS)
    ) u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mrac_datapath #(
        .POLY_DEGREE (POLY_DEGREE),
        .KEPT_TERMS  (KEPT_TERMS)
    ) u_datapath (
        .clk               (clk),
        .cmd               (cmd),
        .elementary_coeffs (elementary_coeffs),
        .remainder_coeffs  (remainder_coeffs),
        .agreement_total   (agreement_total),
        .status            (status)
    );

endmodule

`default_nettype wire

[rtl/mrac_controller.sv]
`default_nettype none

module mrac_controller
    import mrac_pkg::*;
#(
    parameter int KEPT_TERMS = KEPT_TERMS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd
);

    localparam int TERM_W = $clog2(KEPT_TERMS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_REDUCE  = 3'd1;
    localparam logic [2:0] S_PREP    = 3'd2;
    localparam logic [2:0] S_HORNER  = 3'd3;
    localparam logic [2:0] S_COMPARE = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TERM_W-1:0]     term_reg, term_next;
    logic [GROUP_BITS-1:0] group_reg, group_next;
    logic                  out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            term_reg      <= '0;
            group_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            term_reg      <= term_next;
            group_reg     <= group_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        term_next      = term_reg;
        group_next     = group_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.group      = group_reg;
        cmd.first      = (term_reg == '0);
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_W'(MONO_EXP - 1))
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                term_next  = '0;
                group_next = '0;
                state_next = S_HORNER;
            end
            S_HORNER:
            begin
                cmd.step  = 1'b1;
                term_next = term_reg + 1'b1;
                if (term_reg == TERM_W'(KEPT_TERMS - 1))
                    state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                term_next   = '0;
                group_next  = group_reg + 1'b1;
                if (group_reg == '1)
                    state_next = S_FINISH;
                else
                    state_next = S_HORNER;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/mrac_datapath.sv]
`default_nettype none

module mrac_datapath
    import mrac_pkg::*;
#(
    parameter int POLY_DEGREE = POLY_DEGREE_DEF,
    parameter int KEPT_TERMS  = KEPT_TERMS_DEF
)
(
    input  wire logic              clk,
    input  wire dp_cmd_t           cmd,
    input  wire logic [IN_W-1:0]   elementary_coeffs,
    output logic [OUT_W-1:0]       remainder_coeffs,
    output logic [CNT_W-1:0]       agreement_total,
    output logic [ST_W-1:0]        status
);

    logic [1:0]       modc_reg [POLY_DEGREE];
    logic [1:0]       rem_reg  [POLY_DEGREE];
    logic [1:0]       rem_next [POLY_DEGREE];
    logic [1:0]       h_reg    [KEPT_TERMS];
    logic [7:0]       val_reg  [LANES];
    logic [7:0]       val_next [LANES];
    logic [LANES-1:0] match;
    logic [1:0]       lead;
    logic [1:0]       code;
    logic [CNT_W-1:0] count_reg;
    logic             high_nonzero;
    logic [ST_W-1:0]  status_next;
    logic [OUT_W-1:0] packed_rem;
    logic [OUT_W-1:0] rem_out_reg;
    logic [CNT_W-1:0] total_out_reg;
    logic [ST_W-1:0]  status_out_reg;

    always_comb
    begin
        lead        = rem_reg[POLY_DEGREE-1];
        rem_next[0] = gf4_mul(lead, modc_reg[0]);
        for (int i = 1; i < POLY_DEGREE; i++)
            rem_next[i] = rem_reg[i-1] ^ gf4_mul(lead, modc_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < POLY_DEGREE; i++)
            begin
                if (2 * (POLY_DEGREE - 1 - i) < IN_W)
                    modc_reg[i] <= elementary_coeffs[2 * (POLY_DEGREE - 1 - i) +: 2];
                else
                    modc_reg[i] <= 2'd0;
                rem_reg[i] <= (i == 0) ? 2'd1 : 2'd0;
            end
        end
        else if (cmd.reduce)
        begin
            for (int i = 0; i < POLY_DEGREE; i++)
                rem_reg[i] <= rem_next[i];
        end
    end

    for (genvar gi = 0; gi < KEPT_TERMS; gi++)
    begin : g_horner_taps
        localparam int PREV = (gi == 0) ? KEPT_TERMS - 1 : gi - 1;
        logic [1:0] init_code;
        if (gi < POLY_DEGREE)
        begin : g_kept
            assign init_code = rem_reg[gi];
        end
        else
        begin : g_pad
            assign init_code = 2'd0;
        end
        always_ff @(posedge clk)
        begin
            if (cmd.prep)
                h_reg[gi] <= init_code;
            else if (cmd.step)
                h_reg[gi] <= h_reg[PREV];
        end
    end

    assign code = h_reg[KEPT_TERMS-1];

    for (genvar gl = 0; gl < LANES; gl++)
    begin : g_lanes
        logic [7:0] pt;
        assign pt           = {cmd.group, LANE_BITS'(gl)};
        assign val_next[gl] = gf_mul(cmd.first ? 8'd0 : val_reg[gl], pt) ^ lift(code);
        assign match[gl]    = (val_reg[gl] == POW_TAB[pt]) && (pt != 8'd0);
        always_ff @(posedge clk)
        begin
            if (cmd.step)
                val_reg[gl] <= val_next[gl];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
            count_reg <= '0;
        else if (cmd.compare)
            count_reg <= count_reg + CNT_W'($countones(match));
    end

    always_comb
    begin
        high_nonzero = 1'b0;
        for (int i = 0; i < POLY_DEGREE; i++)
            if (i >= KEPT_TERMS && rem_reg[i] != 2'd0)
                high_nonzero = 1'b1;

        if (rem_reg[0] != 2'd1)
            status_next = ST_CONST;
        else if (high_nonzero)
            status_next = ST_HIGH;
        else if (count_reg < RANGE_LOW || count_reg > RANGE_HIGH)
            status_next = ST_RANGE;
        else
            status_next = ST_OK;

        packed_rem = '0;
        for (int k = 0; k < OUT_TERMS; k++)
            if (k < KEPT_TERMS && k < POLY_DEGREE)
                packed_rem[2*k +: 2] = rem_reg[k];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rem_out_reg    <= packed_rem;
            total_out_reg  <= count_reg;
            status_out_reg <= status_next;
        end
    end

    assign remainder_coeffs = rem_out_reg;
    assign agreement_total  = total_out_reg;
    assign status           = status_out_reg;

endmodule

`default_nettype wire

[verif/tb_monomial_residue_agreement_count.sv]
`timescale 1ns / 1ps

module tb_monomial_residue_agreement_count;
    import mrac_pkg::*;

    localparam int DEGREE     = POLY_DEGREE_DEF;
    localparam int KEPT       = KEPT_TERMS_DEF;
    localparam int EXPONENT   = 146;
    localparam int HALF_DEG   = DEGREE / 2;
    localparam int HALF_EXP   = EXPONENT / 2;
    localparam int ITEMS      = 1170;
    localparam int SETTLE     = 600;

    localparam logic [7:0] FIELD_LOW = 8'h4d;
    localparam int         BAND_LOW  = 24;
    localparam int         BAND_HIGH = 37;

    // entry {a, b} holds the GF(4) product of a and b
    localparam logic [31:0] QUAD_PROD = {2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0,
                                         2'd3, 2'd2, 2'd1, 2'd0, 8'd0};

    typedef struct packed {
        logic [OUT_W-1:0] remainder;
        logic [CNT_W-1:0] total;
        logic [ST_W-1:0]  code;
    } verdict_t;

    typedef struct packed {
        logic [IN_W-1:0] coeffs;
        logic            known;
        verdict_t        verdict;
    } stim_row_t;

    typedef enum {FREE, LIGHT, HEAVY, HOLD, ALTERNATE} stall_mode_t;

    localparam stim_row_t DIRECTED [16] = '{
        {48'h0000_0000_0000, 1'b1, 38'h0,  8'd0, ST_CONST},
        {48'hffff_ffff_ffff, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h5555_5555_5555, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'haaaa_aaaa_aaaa, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h4000_0000_0000, 1'b1, 38'h10, 8'd3, ST_CONST},
        {48'h8000_0000_0000, 1'b1, 38'h10, 8'd3, ST_CONST},
        {48'hc000_0000_0000, 1'b1, 38'h10, 8'd3, ST_CONST},
        {48'h5000_0000_0000, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h0000_0000_0001, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h0000_0000_0003, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h4000_0000_0001, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h7fff_ffff_ffff, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h4000_0040_0000, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h4000_4000_4000, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'h4924_9249_2492, 1'b0, 38'h0,  8'd0, ST_OK},
        {48'hb6db_6db6_db6d, 1'b0, 38'h0,  8'd0, ST_OK}
    };

    logic                clk               = 1'b0;
    logic                rst_n             = 1'b0;
    logic                in_valid          = 1'b0;
    logic [IN_W-1:0]     elementary_coeffs = '0;
    logic                out_ready         = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [OUT_W-1:0]    remainder_coeffs;
    logic [CNT_W-1:0]    agreement_total;
    logic [ST_W-1:0]     status;

    logic [7:0] field_prod [0:65535];
    logic [7:0] power146   [0:255];
    logic [7:0] lift_code  [0:3];
    verdict_t   queued_verdicts [$];
    int         mismatches = 0;
    int         burst_left = 0;

    monomial_residue_agreement_count dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .elementary_coeffs (elementary_coeffs),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .remainder_coeffs  (remainder_coeffs),
        .agreement_total   (agreement_total),
        .status            (status)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [1:0] quad_mul(input logic [1:0] a, input logic [1:0] b);
        return QUAD_PROD[2 * {a, b} +: 2];
    endfunction

    // swap between e1..e24 order and x^0..x^23 order
    function automatic logic [IN_W-1:0] swap_order(input logic [IN_W-1:0] w);
        logic [IN_W-1:0] r;
        for (int i = 0; i < DEGREE; i++)
            r[2 * i +: 2] = w[2 * (DEGREE - 1 - i) +: 2];
        return r;
    endfunction

    // x^exponent modulo the monic polynomial of the given degree whose lower
    // terms are low_terms (x^i at bits 2i and 2i+1)
    function automatic logic [IN_W-1:0] power_residue(input logic [IN_W-1:0] low_terms,
                                                      input int degree, input int exponent);
        logic [IN_W-1:0] acc;
        logic [IN_W-1:0] mask;
        logic [1:0]      lead;
        mask = (48'd1 << (2 * degree)) - 48'd1;
        acc  = 48'd1;
        for (int s = 0; s < exponent; s++)
        begin
            lead = acc[2 * (degree - 1) +: 2];
            acc  = (acc << 2) & mask;
            if (lead != 2'd0)
                for (int i = 0; i < degree; i++)
                    acc[2 * i +: 2] = acc[2 * i +: 2] ^ quad_mul(lead, low_terms[2 * i +: 2]);
        end
        return acc;
    endfunction

    function automatic verdict_t agreement_verdict(input logic [IN_W-1:0] coeffs);
        verdict_t        v;
        logic [IN_W-1:0] rem;
        logic [7:0]      acc;
        int              hits;
        rem         = power_residue(swap_order(coeffs), DEGREE, EXPONENT);
        v.remainder = rem[OUT_W-1:0];
        if (rem[1:0] != 2'd1)
            v.code = ST_CONST;
        else if ((rem >> (2 * KEPT)) != '0)
            v.code = ST_HIGH;
        else
            v.code = ST_OK;
        hits = 0;
        for (int pt = 1; pt < 256; pt++)
        begin
            acc = 8'd0;
            for (int i = KEPT - 1; i >= 0; i--)
                acc = field_prod[{acc, 8'(pt)}] ^ lift_code[rem[2 * i +: 2]];
            if (acc == power146[pt])
                hits++;
        end
        v.total = CNT_W'(hits);
        if (v.code == ST_OK && (hits < BAND_LOW || hits > BAND_HIGH))
            v.code = ST_RANGE;
        return v;
    endfunction

    // P = Q^2 gives x^146 mod P = (x^73 mod Q)^2, so a Q whose residue has
    // constant 1 and low degree yields a remainder that passes the early checks
    function automatic logic [IN_W-1:0] squared_modulus(input bit strict);
        logic [IN_W-1:0] root;
        logic [IN_W-1:0] res;
        logic [IN_W-1:0] low;
        bit              hit;
        hit = 1'b0;
        while (!hit)
        begin
            root = IN_W'($urandom_range(32'hff_ffff));
            res  = power_residue(root, HALF_DEG, HALF_EXP);
            hit  = res[1:0] == 2'd1 && (!strict || (res >> (2 * ((KEPT + 1) / 2))) == '0);
        end
        low = '0;
        for (int i = 0; i < HALF_DEG; i++)
            low[4 * i +: 2] = quad_mul(root[2 * i +: 2], root[2 * i +: 2]);
        return swap_order(low);
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, wanted);
        mismatches++;
    endtask

    task automatic offer(input logic [IN_W-1:0] coeffs, input logic known, input verdict_t given);
        verdict_t want;
        want = known ? given : agreement_verdict(coeffs);
        in_valid          <= 1'b1;
        elementary_coeffs <= coeffs;
        do
            @(posedge clk);
        while (!in_ready);
        queued_verdicts.insert(queued_verdicts.size(), want);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid   <= 1'b0;
            burst_left = $urandom_range(12);
            if ($urandom_range(15) == 0)
                repeat ($urandom_range(520, 1)) @(posedge clk);
            else
                repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [7:0]      p;
        logic [7:0]      sq;
        logic [7:0]      two;
        logic [IN_W-1:0] coeffs;
        verdict_t        blank;
        int              slot;
        blank = '0;
        for (int a = 0; a < 256; a++)
        begin
            field_prod[a << 8] = 8'd0;
            for (int b = 1; b < 256; b++)
            begin
                p = field_prod[(a << 8) | (b >> 1)];
                p = {p[6:0], 1'b0} ^ (p[7] ? FIELD_LOW : 8'd0);
                field_prod[(a << 8) | b] = (b & 1) ? p ^ 8'(a) : p;
            end
        end
        for (int q = 0; q < 256; q++)
        begin
            p = 8'd1;
            repeat (EXPONENT) p = field_prod[{p, 8'(q)}];
            power146[q] = p;
        end
        two = 8'd0;
        for (int v = 255; v >= 2; v--)
        begin
            sq = field_prod[{8'(v), 8'(v)}];
            if (field_prod[{sq, sq}] == 8'(v))
                two = 8'(v);
        end
        lift_code[0] = 8'd0;
        lift_code[1] = 8'd1;
        lift_code[2] = two;
        lift_code[3] = two ^ 8'd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < $size(DIRECTED); k++)
            offer(DIRECTED[k].coeffs, DIRECTED[k].known, DIRECTED[k].verdict);

        for (int n = $size(DIRECTED); n < ITEMS; n++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: coeffs = squared_modulus($urandom_range(3) != 0);
                6, 7, 8:          coeffs = IN_W'({$urandom, $urandom});
                default:
                begin
                    coeffs = '0;
                    coeffs[2 * (DEGREE - 1) +: 2] = 2'($urandom_range(3, 1));
                    repeat ($urandom_range(3))
                    begin
                        slot = $urandom_range(DEGREE - 1);
                        coeffs[2 * slot +: 2] = 2'($urandom_range(3, 1));
                    end
                end
            endcase
            offer(coeffs, 1'b0, blank);
        end
        in_valid <= 1'b0;

        while (queued_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("tb_monomial_residue_agreement_count passed");
        else
            $display("tb_monomial_residue_agreement_count failed");
        $finish;
    end

    initial
    begin
        verdict_t    want;
        stall_mode_t mode;
        int          phase_left;
        int          stall_pct;
        phase_left = 0;
        stall_pct  = 0;
        mode       = FREE;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (queued_verdicts.size() == 0)
                    flag_mismatch("item with nothing awaited", {remainder_coeffs, status}, 0);
                else
                begin
                    want = queued_verdicts.pop_front();
                    if (remainder_coeffs !== want.remainder)
                        flag_mismatch("remainder_coeffs", remainder_coeffs, want.remainder);
                    if (agreement_total !== want.total)
                        flag_mismatch("agreement_total", agreement_total, want.total);
                    if (status !== want.code)
                        flag_mismatch("status", status, want.code);
                end
            end
            if (phase_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(4));
                case (mode)
                    FREE:    stall_pct = 0;
                    LIGHT:   stall_pct = 30;
                    HEAVY:   stall_pct = 85;
                    HOLD:    stall_pct = 100;
                    default: stall_pct = 0;
                endcase
                phase_left = (mode == HOLD) ? $urandom_range(600, 50) : $urandom_range(3000, 50);
            end
            phase_left--;
            if (mode == ALTERNATE)
                out_ready <= !out_ready;
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #25_000_000;
        $display("tb_monomial_residue_agreement_count failed");
        $finish;
    end

endmodule
